// File: rtl/rti_pkg.sv
package rti_pkg;

	localparam int CW = 16;
	localparam int DW = 16;
	localparam int QW = 32;
	// quotient bits are produced over DIV_STG stages, DIV_BITS per stage
	localparam int DIV_STG = 8;
	localparam int DIV_BITS = 4;

	typedef enum logic [1:0] {
		OUT_HIT      = 2'd0,
		OUT_PARALLEL = 2'd1,
		OUT_NEAR     = 2'd2,
		OUT_OUTSIDE  = 2'd3
	} outcome_t;

	localparam logic [1:0] REG_V1 = 2'd0;
	localparam logic [1:0] REG_V2 = 2'd1;
	localparam logic [1:0] REG_V3 = 2'd2;
	localparam logic [1:0] REG_MIN = 2'd3;

	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic signed [15:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] hit_distance;
		logic [1:0]  outcome;
	} res_t;

endpackage

// File: rtl/ray_triangle_intersect_unit.sv
// throughput: one ray per cycle while the output is not stalled; the 32 quotient bits
// are unrolled over 8 divider stages, four quotient bits per stage
// reset: arst_n clears all valid bits and loads vertices to 0, min_distance to 131
// stalls freeze every stage, nothing is lost or repeated
module ray_triangle_intersect_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rti_pkg::ray_t       in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rti_pkg::res_t       out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [47:0]         cfg_data
);

	localparam int NS = 6 + rti_pkg::DIV_STG;

	logic [47:0] v1_q, v2_q, v3_q;
	logic [31:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= '0;
			v2_q <= '0;
			v3_q <= '0;
			min_q <= 32'd131;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rti_pkg::REG_V1: v1_q <= cfg_data;
				rti_pkg::REG_V2: v2_q <= cfg_data;
				rti_pkg::REG_V3: v3_q <= cfg_data;
				rti_pkg::REG_MIN: min_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	logic [NS:1] vld;
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	assign out_valid = vld[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld <= '0;
		else if (adv) vld <= {vld[NS-1:1], in_valid};
	end

	// triangle-constant terms from config
	logic signed [17:0] vc [3][3];
	logic signed [16:0] e1 [3], e2 [3];
	logic signed [34:0] nrm [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vc[0][k] = 18'(signed'(v1_q[16*k +: 16]));
			vc[1][k] = 18'(signed'(v2_q[16*k +: 16]));
			vc[2][k] = 18'(signed'(v3_q[16*k +: 16]));
			e1[k] = 17'(vc[1][k] - vc[0][k]);
			e2[k] = 17'(vc[2][k] - vc[0][k]);
		end
	end

	// stage 1: relative vertices, normal products
	logic signed [16:0] a_s1 [3][3];
	logic signed [15:0] d_s1 [3];
	logic signed [33:0] np_s1 [6];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				a_s1[0][k] <= 17'(vc[0][k] - 18'(signed'(in_data[95-16*k -: 16])));
				a_s1[1][k] <= 17'(vc[1][k] - 18'(signed'(in_data[95-16*k -: 16])));
				a_s1[2][k] <= 17'(vc[2][k] - 18'(signed'(in_data[95-16*k -: 16])));
			end
			d_s1[0] <= in_data.dir_x;
			d_s1[1] <= in_data.dir_y;
			d_s1[2] <= in_data.dir_z;
			np_s1[0] <= e1[1] * e2[2];
			np_s1[1] <= e1[2] * e2[1];
			np_s1[2] <= e1[2] * e2[0];
			np_s1[3] <= e1[0] * e2[2];
			np_s1[4] <= e1[0] * e2[1];
			np_s1[5] <= e1[1] * e2[0];
		end
	end
	always_comb
		for (int k = 0; k < 3; k++)
			nrm[k] = 35'(np_s1[2*k]) - 35'(np_s1[2*k+1]);

	// stage 2: edge cross products, nrm carried
	logic signed [33:0] cp_s2 [3][6];
	logic signed [34:0] n_s2 [3];
	logic signed [16:0] a0_s2 [3];
	logic signed [15:0] d_s2 [3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				cp_s2[i][0] <= a_s1[i][1] * a_s1[(i+1)%3][2];
				cp_s2[i][1] <= a_s1[i][2] * a_s1[(i+1)%3][1];
				cp_s2[i][2] <= a_s1[i][2] * a_s1[(i+1)%3][0];
				cp_s2[i][3] <= a_s1[i][0] * a_s1[(i+1)%3][2];
				cp_s2[i][4] <= a_s1[i][0] * a_s1[(i+1)%3][1];
				cp_s2[i][5] <= a_s1[i][1] * a_s1[(i+1)%3][0];
				n_s2[i] <= nrm[i];
				a0_s2[i] <= a_s1[0][i];
				d_s2[i] <= d_s1[i];
			end
		end
	end

	// stage 3: all dot-product terms
	logic signed [51:0] nt_s3 [3], dt_s3 [3];
	logic signed [50:0] et_s3 [3][3];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				nt_s3[k] <= 52'(a0_s2[k]) * 52'(n_s2[k]);
				dt_s3[k] <= 52'(d_s2[k]) * 52'(n_s2[k]);
			end
			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					et_s3[i][k] <= 51'(cp_s2[i][2*k] - cp_s2[i][2*k+1]) * 51'(d_s2[k]);
		end
	end

	// stage 4: sums and early decisions
	logic signed [53:0] num4, den4;
	logic signed [52:0] t4 [3];
	logic signed [53:0] num_s4, den_s4;
	logic               edge_ok_s4;
	always_comb begin
		num4 = 54'(nt_s3[0]) + 54'(nt_s3[1]) + 54'(nt_s3[2]);
		den4 = 54'(dt_s3[0]) + 54'(dt_s3[1]) + 54'(dt_s3[2]);
		for (int i = 0; i < 3; i++)
			t4[i] = 53'(et_s3[i][0]) + 53'(et_s3[i][1]) + 53'(et_s3[i][2]);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4 <= num4;
			den_s4 <= den4;
			edge_ok_s4 <= den4[53] ?
				(t4[0][52] && t4[1][52] && t4[2][52]) :
				(!t4[0][52] && t4[0] != 0 && !t4[1][52] && t4[1] != 0 &&
				 !t4[2][52] && t4[2] != 0);
		end
	end

	// stage 5: classify, magnitudes for divider
	logic [53:0] nmag, dmag;
	assign nmag = num_s4[53] ? 54'(-num_s4) : 54'(num_s4);
	assign dmag = den_s4[53] ? 54'(-den_s4) : 54'(den_s4);

	typedef struct packed {
		logic [1:0] code;
		logic       edge_ok;
		logic       sat;
	} cls_t;

	logic [31:0]             dvd_s [5:NS-1];
	logic [54:0]             rem_s [5:NS-1];
	logic [53:0]             dvs_s [5:NS-1];
	logic [rti_pkg::QW-1:0]  quo_s [5:NS-1];
	cls_t                    cls_s [5:NS-1];

	// the quotient of (nmag << 22) / dmag reaches 2^32 exactly when nmag >> 10 >= dmag,
	// otherwise nmag >> 10 is already the partial remainder before the low 32 bits
	always_ff @(posedge clk) begin
		if (adv) begin
			dvd_s[5] <= {nmag[9:0], 22'd0};
			rem_s[5] <= 55'(nmag[53:10]);
			dvs_s[5] <= dmag;
			quo_s[5] <= '0;
			cls_s[5].edge_ok <= edge_ok_s4;
			cls_s[5].sat <= (54'(nmag[53:10]) >= dmag);
			if (den_s4 == 0) cls_s[5].code <= rti_pkg::OUT_PARALLEL;
			else if (num_s4 != 0 && (num_s4[53] != den_s4[53]))
				cls_s[5].code <= rti_pkg::OUT_NEAR;
			else cls_s[5].code <= rti_pkg::OUT_HIT;
		end
	end

	// stages 6..13: restoring division, 32 quotient bits, 4 per stage
	for (genvar g = 6; g <= NS - 1; g++) begin : g_div
		logic [31:0]            dv;
		logic [54:0]            r;
		logic [rti_pkg::QW-1:0] q;
		always_comb begin
			dv = dvd_s[g-1];
			r = rem_s[g-1];
			q = quo_s[g-1];
			for (int b = 0; b < rti_pkg::DIV_BITS; b++) begin
				r = {r[53:0], dv[31]};
				dv = {dv[30:0], 1'b0};
				if (r >= {1'b0, dvs_s[g-1]} && dvs_s[g-1] != 0) begin
					r = r - {1'b0, dvs_s[g-1]};
					q = {q[rti_pkg::QW-2:0], 1'b1};
				end else begin
					q = {q[rti_pkg::QW-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dvd_s[g] <= dv;
				rem_s[g] <= r;
				quo_s[g] <= q;
				dvs_s[g] <= dvs_s[g-1];
				cls_s[g] <= cls_s[g-1];
			end
		end
	end

	// stage 14: saturation and min compare
	logic [31:0] quo_sat;
	assign quo_sat = cls_s[NS-1].sat ? 32'hFFFF_FFFF : quo_s[NS-1];
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.hit <= 1'b0;
			out_data.hit_distance <= '0;
			if (cls_s[NS-1].code != rti_pkg::OUT_HIT)
				out_data.outcome <= cls_s[NS-1].code;
			else if (quo_sat < min_q)
				out_data.outcome <= rti_pkg::OUT_NEAR;
			else if (!cls_s[NS-1].edge_ok)
				out_data.outcome <= rti_pkg::OUT_OUTSIDE;
			else begin
				out_data.outcome <= rti_pkg::OUT_HIT;
				out_data.hit <= 1'b1;
				out_data.hit_distance <= quo_sat;
			end
		end
	end

endmodule

// File: rtl/rti_checker.sv
module rti_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input rti_pkg::res_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.hit_distance == 0)
		else $error("miss with nonzero distance");

	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.hit == (out_data.outcome == rti_pkg::OUT_HIT))
		else $error("hit flag and outcome disagree");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind ray_triangle_intersect_unit rti_checker u_rti_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// File: test/tb_ray_triangle_intersect_unit.sv
`timescale 1ns / 100ps

module tb_ray_triangle_intersect_unit;

	localparam int TIMEOUT_NS = 4000000;

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	rti_pkg::ray_t in_data;
	logic          out_valid;
	logic          out_ready;
	rti_pkg::res_t out_data;
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [47:0]   cfg_data;

	ray_triangle_intersect_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// triangle and threshold as the block should hold them
	logic [47:0] tri_v1, tri_v2, tri_v3;
	logic [31:0] near_limit;

	rti_pkg::res_t hit_queue[$];
	int   n_errors;
	bit   rx_stall_on;

	typedef struct {
		rti_pkg::ray_t ray;
		bit            has_fixed;
		rti_pkg::res_t fixed;
	} ray_row_t;

	ray_row_t ray_rows[$];

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		n_errors++;
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
	endtask

	function automatic logic signed [15:0] coord(input logic [47:0] v, input int k);
		return v[k*16 +: 16];
	endfunction

	function automatic rti_pkg::res_t trace_ray(input rti_pkg::ray_t r);
		logic signed [63:0]  p[3][3];
		logic signed [63:0]  o[3], d[3], e1[3], e2[3], n[3], a[3], b[3], c[3];
		logic signed [63:0]  den, t;
		logic signed [127:0] num;
		logic [127:0]        quo, mag_num, mag_den;
		rti_pkg::res_t       res;
		res = '0;
		for (int k = 0; k < 3; k++) begin
			p[0][k] = coord(tri_v1, k);
			p[1][k] = coord(tri_v2, k);
			p[2][k] = coord(tri_v3, k);
		end
		o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
		d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
		for (int k = 0; k < 3; k++) begin
			e1[k] = p[1][k] - p[0][k];
			e2[k] = p[2][k] - p[0][k];
		end
		n[0] = e1[1]*e2[2] - e1[2]*e2[1];
		n[1] = e1[2]*e2[0] - e1[0]*e2[2];
		n[2] = e1[0]*e2[1] - e1[1]*e2[0];
		den = d[0]*n[0] + d[1]*n[1] + d[2]*n[2];
		if (den == 0) begin
			res.outcome = rti_pkg::OUT_PARALLEL;
			return res;
		end
		num = 128'(p[0][0]-o[0]) * 128'(n[0]) + 128'(p[0][1]-o[1]) * 128'(n[1])
			+ 128'(p[0][2]-o[2]) * 128'(n[2]);
		if (num != 0 && ((num < 0) != (den < 0))) begin
			res.outcome = rti_pkg::OUT_NEAR;
			return res;
		end
		mag_num = num < 0 ? -num : num;
		mag_den = den < 0 ? 128'(-den) : 128'(den);
		quo = (mag_num << 22) / mag_den;
		if (quo > 128'hFFFF_FFFF)
			quo = 128'hFFFF_FFFF;
		if (quo[31:0] < near_limit) begin
			res.outcome = rti_pkg::OUT_NEAR;
			return res;
		end
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				a[k] = p[i][k] - o[k];
				b[k] = p[(i+1)%3][k] - o[k];
			end
			c[0] = a[1]*b[2] - a[2]*b[1];
			c[1] = a[2]*b[0] - a[0]*b[2];
			c[2] = a[0]*b[1] - a[1]*b[0];
			t = c[0]*d[0] + c[1]*d[1] + c[2]*d[2];
			if (den < 0)
				t = -t;
			if (t <= 0) begin
				res.outcome = rti_pkg::OUT_OUTSIDE;
				return res;
			end
		end
		res.hit = 1'b1;
		res.hit_distance = quo[31:0];
		res.outcome = rti_pkg::OUT_HIT;
		return res;
	endfunction

	function automatic logic [47:0] pack_vertex(input int x, input int y, input int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic rti_pkg::ray_t make_ray(input int ox, input int oy, input int oz,
			input int dx, input int dy, input int dz);
		rti_pkg::ray_t r;
		r.origin_x = 16'(ox); r.origin_y = 16'(oy); r.origin_z = 16'(oz);
		r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
		return r;
	endfunction

	function automatic int rand_dir();
		return int'($urandom_range(32768)) - 16384;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			rti_pkg::REG_V1:  tri_v1 = value;
			rti_pkg::REG_V2:  tri_v2 = value;
			rti_pkg::REG_V3:  tri_v3 = value;
			rti_pkg::REG_MIN: near_limit = value[31:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// wait for the pipeline to drain before touching registers
	task automatic drain();
		while (hit_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_ray(input rti_pkg::ray_t r, input bit has_fixed,
			input rti_pkg::res_t fixed);
		int gap;
		rti_pkg::res_t want;
		gap = $urandom_range(18);
		if (gap > 0 && $urandom_range(3) != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		want = trace_ray(r);
		if (has_fixed && want != fixed)
			report_mismatch("table", want, fixed);
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		hit_queue.push_back(want);
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// result side: random stalls, stretches with none
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_stall_on ? $urandom_range(18) : 0;
			if ($urandom_range(3) == 0)
				stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		rti_pkg::res_t want;
		if (arst_n && out_valid && out_ready) begin
			if (hit_queue.size() == 0) begin
				report_mismatch("unexpected beat", out_data, 0);
			end else begin
				want = hit_queue.pop_front();
				if (out_data.hit !== want.hit)
					report_mismatch("hit", out_data.hit, want.hit);
				if (out_data.hit_distance !== want.hit_distance)
					report_mismatch("hit_distance", out_data.hit_distance,
						want.hit_distance);
				if (out_data.outcome !== want.outcome)
					report_mismatch("outcome", out_data.outcome, want.outcome);
			end
		end
	end

	task automatic random_triangle();
		int sz;
		sz = ($urandom_range(7) == 0) ? 32767 : int'($urandom_range(4000));
		write_reg(rti_pkg::REG_V1, pack_vertex($urandom_range(2*sz) - sz,
			$urandom_range(2*sz) - sz, $urandom_range(2*sz) - sz));
		write_reg(rti_pkg::REG_V2, pack_vertex($urandom_range(2*sz) - sz,
			$urandom_range(2*sz) - sz, $urandom_range(2*sz) - sz));
		write_reg(rti_pkg::REG_V3, pack_vertex($urandom_range(2*sz) - sz,
			$urandom_range(2*sz) - sz, $urandom_range(2*sz) - sz));
	endtask

	initial begin
		ray_row_t      row;
		rti_pkg::res_t nores;
		int            lim_pick;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = rti_pkg::REG_V1;
		cfg_data  = '0;
		n_errors  = 0;
		rx_stall_on = 1'b1;
		tri_v1 = '0; tri_v2 = '0; tri_v3 = '0;
		near_limit = 32'd131;
		nores = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset the triangle is degenerate: every ray is parallel
		row.ray = make_ray(0, 0, 0, 16384, 0, 0);
		row.has_fixed = 1; row.fixed = '{1'b0, 32'd0, rti_pkg::OUT_PARALLEL};
		ray_rows.push_back(row);
		row.ray = make_ray(-32768, 32767, -32768, -16384, 16384, -16384);
		ray_rows.push_back(row);
		foreach (ray_rows[i])
			send_ray(ray_rows[i].ray, ray_rows[i].has_fixed, ray_rows[i].fixed);
		end_burst();
		drain();

		// triangle in the z=0 plane: (0,0,0) (1,0,0) (0,1,0) in Q8.8
		write_reg(rti_pkg::REG_V1, pack_vertex(0, 0, 0));
		write_reg(rti_pkg::REG_V2, pack_vertex(256, 0, 0));
		write_reg(rti_pkg::REG_V3, pack_vertex(0, 256, 0));
		ray_rows.delete();
		row.has_fixed = 0;
		// straight hit from z=1 downward
		row.ray = make_ray(64, 64, 256, 0, 0, -16384); ray_rows.push_back(row);
		// behind the origin
		row.ray = make_ray(64, 64, 256, 0, 0, 16384); ray_rows.push_back(row);
		// parallel ray
		row.ray = make_ray(64, 64, 256, 16384, 0, 0); ray_rows.push_back(row);
		// outside the edges
		row.ray = make_ray(512, 512, 256, 0, 0, -16384); ray_rows.push_back(row);
		// on an edge
		row.ray = make_ray(0, 64, 256, 0, 0, -16384); ray_rows.push_back(row);
		// origin in the plane: distance 0, below the reset limit
		row.ray = make_ray(64, 64, 0, 0, 0, -16384); ray_rows.push_back(row);
		// non-unit direction and large origin, saturating distance
		row.ray = make_ray(64, 64, 32767, 0, 0, -1); ray_rows.push_back(row);
		row.ray = make_ray(64, 64, -32768, 0, 0, 16384); ray_rows.push_back(row);
		row.ray = make_ray(64, 64, 256, 0, 0, -32768); ray_rows.push_back(row);
		row.ray = make_ray(64, 64, -256, 16384, 16384, 16384); ray_rows.push_back(row);
		foreach (ray_rows[i])
			send_ray(ray_rows[i].ray, 0, nores);
		end_burst();
		drain();

		// limits: zero accepts distance 0, equal is accepted, max rejects most
		write_reg(rti_pkg::REG_MIN, 48'd0);
		send_ray(make_ray(64, 64, 0, 0, 0, -16384), 0, nores);
		end_burst();
		drain();
		write_reg(rti_pkg::REG_MIN, 48'h0001_0000);
		send_ray(make_ray(64, 64, 256, 0, 0, -16384), 0, nores);
		end_burst();
		drain();
		write_reg(rti_pkg::REG_MIN, 48'hFFFF_FFFF_FFFF);
		send_ray(make_ray(64, 64, 256, 0, 0, -16384), 0, nores);
		send_ray(make_ray(64, 64, 32767, 0, 0, -1), 0, nores);
		end_burst();
		drain();
		// extreme vertex coordinates
		write_reg(rti_pkg::REG_MIN, 48'd131);
		write_reg(rti_pkg::REG_V1, 48'h8000_8000_8000);
		write_reg(rti_pkg::REG_V2, 48'h7FFF_7FFF_8000);
		write_reg(rti_pkg::REG_V3, 48'h8000_7FFF_7FFF);
		send_ray(make_ray(0, 0, 0, 9459, 9459, 9459), 0, nores);
		send_ray(make_ray(-32768, -32768, -32768, 16384, 0, 0), 0, nores);
		end_burst();
		drain();

		// random phases: new triangle and limit, then rays aimed near it
		for (int ph = 0; ph < 33; ph++) begin
			random_triangle();
			lim_pick = $urandom_range(5);
			case (lim_pick)
				0: write_reg(rti_pkg::REG_MIN, 48'd0);
				1: write_reg(rti_pkg::REG_MIN, 48'hFFFF_FFFF);
				2: write_reg(rti_pkg::REG_MIN, {16'd0, 32'($urandom())});
				default: write_reg(rti_pkg::REG_MIN, 48'($urandom_range(300000)));
			endcase
			rx_stall_on = (ph % 4 != 3);
			for (int i = 0; i < 50; i++) begin
				rti_pkg::ray_t r;
				logic signed [15:0] tx, ty, tz;
				int w1, w2, ox, oy, oz;
				if ($urandom_range(4) == 0) begin
					r = rti_pkg::ray_t'({$urandom(), $urandom(), $urandom()});
					r.dir_x = 16'(rand_dir()); r.dir_y = 16'(rand_dir());
					r.dir_z = 16'(rand_dir());
				end else begin
					// aim through a point blended from the vertices
					w1 = $urandom_range(256); w2 = $urandom_range(256 - w1);
					tx = 16'((coord(tri_v1,0)*(256-w1-w2) + coord(tri_v2,0)*w1
						+ coord(tri_v3,0)*w2) / 256);
					ty = 16'((coord(tri_v1,1)*(256-w1-w2) + coord(tri_v2,1)*w1
						+ coord(tri_v3,1)*w2) / 256);
					tz = 16'((coord(tri_v1,2)*(256-w1-w2) + coord(tri_v2,2)*w1
						+ coord(tri_v3,2)*w2) / 256);
					ox = $urandom_range(4000) - 2000;
					oy = $urandom_range(4000) - 2000;
					oz = $urandom_range(4000) - 2000;
					r = make_ray(tx + ox, ty + oy, tz + oz,
						-ox * 4, -oy * 4, -oz * 4);
					if ($urandom_range(5) == 0)
						r.dir_x = -r.dir_x;
				end
				send_ray(r, 0, nores);
			end
			end_burst();
			drain();
		end

		rx_stall_on = 1'b1;
		drain();
		if (n_errors == 0 && hit_queue.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
rtl/rti_pkg.sv
rtl/ray_triangle_intersect_unit.sv
rtl/rti_checker.sv
test/tb_ray_triangle_intersect_unit.sv
